// File: hdl/pbrrs_pkg.sv
package pbrrs_pkg;

    localparam int TASK_ID_W   = 5;
    localparam int PRIORITY_W  = 6;
    localparam int OPERATION_W = 3;
    localparam int COUNT_W     = 6;

    // widest task index and level index the list store can be built for
    localparam int TASK_IDX_W  = 8;
    localparam int LEVEL_W     = 6;

    localparam logic [23:0] CLOCK_PERIOD_RST = 24'd1000000;
    localparam logic [31:0] MIN_SWITCH_RST   = 32'd10000000;

    typedef enum logic [OPERATION_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_CHANGE = 3'd2,
        OP_YIELD  = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic {
        REG_CLOCK_PERIOD = 1'b0,
        REG_MIN_SWITCH   = 1'b1
    } t_reg;

    typedef struct packed {
        logic [OPERATION_W-1:0] operation;
        logic [TASK_ID_W-1:0]   task_id;
        logic [PRIORITY_W-1:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic                   running_valid;
        logic [TASK_ID_W-1:0]   running_task;
        logic                   status;
        logic [COUNT_W-1:0]     task_count;
    } t_out_item;

    // one unlink and/or one push of the same task per operation
    typedef struct packed {
        logic                  unlink;
        logic                  push;
        logic                  keep_level;
        logic [TASK_IDX_W-1:0] task_idx;
        logic [LEVEL_W-1:0]    level;
    } t_list_cmd;

    // state of the queues once the command has been applied
    typedef struct packed {
        logic                  any;
        logic [TASK_IDX_W-1:0] best_task;
    } t_list_view;

endpackage

// File: hdl/priority_bitmap_round_robin_scheduler.sv
// Task scheduler with one FIFO of task ids per priority level (level 0 most
// urgent) and a ready bitmap. Each transfer on the input channel is one
// operation (add, remove, change priority, yield, tick) and produces exactly
// one result: the running task after the operation, a reject flag and the
// number of tasks held. The block takes one operation per clock cycle while
// the output is not stalled; an operation is held in the input register while
// the queue links, the ready bitmap and the lowest-level encoder are updated
// in a single pass, and its result is then captured in the output register.
// No clearing pass is needed after reset. The clock period and switch interval
// registers are written over the APB port at byte addresses 0 and 4 and should
// only be changed while the block is idle.
module priority_bitmap_round_robin_scheduler #(
    parameter int PRIORITY_LEVELS = 64,
    parameter int MAX_TASKS       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pbrrs_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pbrrs_pkg::t_out_item  o_out_item,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import pbrrs_pkg::*;

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic [23:0]          r_period;
    logic [31:0]          r_min_switch;

    logic                 r_in_valid;
    t_in_item             r_in;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [MAX_TASKS-1:0] r_present;
    logic [COUNT_W-1:0]   r_count;
    logic [TW-1:0]        r_cur;
    logic                 r_cur_valid;
    logic                 r_skip;
    logic [32:0]          r_elapsed;

    logic [COUNT_W-1:0]   n_count;
    logic [TW-1:0]        n_cur;
    logic                 n_cur_valid;
    logic                 n_skip;
    logic [32:0]          n_elapsed;
    logic                 n_reject;
    logic                 set_present;
    logic                 clr_present;

    logic                 advance;
    logic [TW-1:0]        tid;
    logic                 id_ok;
    logic                 pri_ok;
    logic [32:0]          tick_sum;
    logic [TW-1:0]        best;
    t_list_cmd            cmd;
    t_list_cmd            cmd_q;
    t_list_view           view;

    assign pready = 1'b1;
    assign prdata = (t_reg'(paddr[2]) == REG_MIN_SWITCH) ? r_min_switch : {8'd0, r_period};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= CLOCK_PERIOD_RST;
            r_min_switch <= MIN_SWITCH_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (t_reg'(paddr[2]))
                REG_CLOCK_PERIOD: r_period     <= pwdata[23:0];
                REG_MIN_SWITCH:   r_min_switch <= pwdata;
                default:          r_period     <= r_period;
            endcase
        end
    end

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign tid      = TW'(r_in.task_id);
    assign id_ok    = {4'd0, r_in.task_id} < 9'(MAX_TASKS);
    assign pri_ok   = {1'b0, r_in.priority_req} < 7'(PRIORITY_LEVELS);
    assign tick_sum = r_elapsed + 33'(r_period);
    assign best     = TW'(view.best_task);
    assign cmd_q    = advance ? cmd : '0;

    pbrrs_lists #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS),
        .MAX_TASKS       (MAX_TASKS)
    ) u_lists (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_q),
        .o_view  (view)
    );

    always_comb begin
        n_reject    = 1'b0;
        n_count     = r_count;
        n_cur       = r_cur;
        n_cur_valid = r_cur_valid;
        n_skip      = r_skip;
        n_elapsed   = r_elapsed;
        set_present = 1'b0;
        clr_present = 1'b0;
        cmd         = '0;
        case (r_in.operation)
            OP_ADD: begin
                if (!id_ok || !pri_ok || r_present[tid]) begin
                    n_reject = 1'b1;
                end else begin
                    cmd.push     = 1'b1;
                    cmd.task_idx = TASK_IDX_W'(tid);
                    cmd.level    = r_in.priority_req;
                    set_present  = 1'b1;
                    n_count      = r_count + 1'b1;
                    if (!r_cur_valid) begin
                        n_cur       = tid;
                        n_cur_valid = 1'b1;
                    end
                end
            end
            OP_REMOVE: begin
                if (!id_ok || !r_present[tid]) begin
                    n_reject = 1'b1;
                end else begin
                    cmd.unlink   = 1'b1;
                    cmd.task_idx = TASK_IDX_W'(tid);
                    clr_present  = 1'b1;
                    n_count      = r_count - 1'b1;
                    if (r_cur_valid && (r_cur == tid)) begin
                        if (n_count == '0) begin
                            n_cur_valid = 1'b0;
                            n_cur       = '0;
                        end else begin
                            n_cur  = best;
                            n_skip = 1'b1;
                        end
                    end
                end
            end
            OP_CHANGE: begin
                if (!id_ok || !pri_ok || !r_present[tid]) begin
                    n_reject = 1'b1;
                end else begin
                    cmd.unlink   = 1'b1;
                    cmd.push     = 1'b1;
                    cmd.task_idx = TASK_IDX_W'(tid);
                    cmd.level    = r_in.priority_req;
                end
            end
            OP_YIELD: begin
                if ((r_count != '0) && r_cur_valid) begin
                    cmd.unlink     = 1'b1;
                    cmd.push       = 1'b1;
                    cmd.keep_level = 1'b1;
                    cmd.task_idx   = TASK_IDX_W'(r_cur);
                    if (best != r_cur) begin
                        n_cur  = best;
                        n_skip = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if ((r_count != '0) && r_cur_valid) begin
                    n_elapsed = tick_sum;
                    if (tick_sum >= {1'b0, r_min_switch}) begin
                        n_elapsed = '0;
                        if (!r_skip) begin
                            cmd.unlink     = 1'b1;
                            cmd.push       = 1'b1;
                            cmd.keep_level = 1'b1;
                            cmd.task_idx   = TASK_IDX_W'(r_cur);
                            n_cur          = best;
                        end else begin
                            n_skip = 1'b0;
                        end
                    end
                end
            end
            default: begin
                n_reject = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_present   <= '0;
            r_count     <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_skip      <= 1'b0;
            r_elapsed   <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
                r_cur       <= n_cur;
                r_cur_valid <= n_cur_valid;
                r_skip      <= n_skip;
                r_elapsed   <= n_elapsed;
                if (set_present) begin
                    r_present[tid] <= 1'b1;
                end
                if (clr_present) begin
                    r_present[tid] <= 1'b0;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out.running_valid <= n_cur_valid;
            r_out.running_task  <= n_cur_valid ? TASK_ID_W'(n_cur) : '0;
            r_out.status        <= n_reject;
            r_out.task_count    <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_running_iff_tasks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.running_valid == (r_out.task_count != '0)))
        else $error("running flag disagrees with task count");

    a_current_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> r_present[r_cur])
        else $error("running task is not held");

    a_reject_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_reject) |=> (r_count == $past(r_count)))
        else $error("rejected operation changed the task count");
`endif

endmodule

// File: hdl/pbrrs_lists.sv
module pbrrs_lists #(
    parameter int PRIORITY_LEVELS = 64,
    parameter int MAX_TASKS       = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pbrrs_pkg::t_list_cmd   i_cmd,
    output pbrrs_pkg::t_list_view  o_view
);
    import pbrrs_pkg::*;

    localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int LW = $clog2(PRIORITY_LEVELS);

    // head and tail of each queue are flagged per task; a level's head or
    // tail is found by matching the flag against the task's level
    logic [TW-1:0] r_next [MAX_TASKS];
    logic [TW-1:0] r_prev [MAX_TASKS];
    logic [LW-1:0] r_level [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_first;
    logic [MAX_TASKS-1:0] r_last;
    logic [PRIORITY_LEVELS-1:0] r_ready;

    logic [TW-1:0] u;
    logic [LW-1:0] lu;
    logic [LW-1:0] lp;
    logic [TW-1:0] nx;
    logic [TW-1:0] pv;
    logic          is_head;
    logic          is_tail;
    logic          both;
    logic          busy;
    logic [TW-1:0] tail_lp;
    logic [TW-1:0] tail_mid;
    logic [TW-1:0] head_best;
    logic [PRIORITY_LEVELS-1:0] ready_mid;
    logic [PRIORITY_LEVELS-1:0] n_ready;
    logic [MAX_TASKS-1:0] n_first;
    logic [MAX_TASKS-1:0] n_last;
    logic [LW-1:0] best_lv;
    logic [TW-1:0] best_head;

    always_comb begin
        u        = TW'(i_cmd.task_idx);
        lu       = r_level[u];
        lp       = i_cmd.keep_level ? lu : LW'(i_cmd.level);
        nx       = r_next[u];
        pv       = r_prev[u];
        is_head  = r_first[u];
        is_tail  = r_last[u];
        both     = is_head && is_tail;

        ready_mid = r_ready;
        if (i_cmd.unlink && both) begin
            ready_mid[lu] = 1'b0;
        end
        busy = ready_mid[lp];

        n_ready = ready_mid;
        if (i_cmd.push) begin
            n_ready[lp] = 1'b1;
        end

        best_lv = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (n_ready[i]) begin
                best_lv = LW'(i);
            end
        end

        tail_lp   = '0;
        head_best = '0;
        for (int t = 0; t < MAX_TASKS; t++) begin
            if (r_last[t] && (r_level[t] == lp)) begin
                tail_lp = TW'(t);
            end
            if (r_first[t] && (r_level[t] == best_lv)) begin
                head_best = TW'(t);
            end
        end

        // tail of the target level as left by the unlink
        if (i_cmd.unlink && !both && is_tail && (lp == lu)) begin
            tail_mid = pv;
        end else begin
            tail_mid = tail_lp;
        end

        n_first = r_first;
        n_last  = r_last;
        if (i_cmd.unlink) begin
            n_first[u] = 1'b0;
            n_last[u]  = 1'b0;
            if (!both && is_head) begin
                n_first[nx] = 1'b1;
            end
            if (!both && is_tail) begin
                n_last[pv] = 1'b1;
            end
        end
        if (i_cmd.push) begin
            if (!busy) begin
                n_first[u] = 1'b1;
            end else begin
                n_last[tail_mid] = 1'b0;
            end
            n_last[u] = 1'b1;
        end

        if (i_cmd.push && !busy && (lp == best_lv)) begin
            best_head = u;
        end else if (i_cmd.unlink && !both && is_head && (lu == best_lv)) begin
            best_head = nx;
        end else begin
            best_head = head_best;
        end

        o_view.any       = |n_ready;
        o_view.best_task = TASK_IDX_W'(best_head);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            r_first <= '0;
            r_last  <= '0;
        end else begin
            r_ready <= n_ready;
            r_first <= n_first;
            r_last  <= n_last;
        end
    end

    // the link past a queue's tail and the one before its head are never
    // read, so an unlink only rewires around a task in the middle
    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink && !is_head && !is_tail) begin
            r_next[pv] <= nx;
            r_prev[nx] <= pv;
        end
        if (i_cmd.push) begin
            if (busy) begin
                r_next[tail_mid] <= u;
                r_prev[u]        <= tail_mid;
            end
            if (!i_cmd.keep_level) begin
                r_level[u] <= lp;
            end
        end
    end

endmodule
